/* rtl/bfd_pkg.sv */
package bfd_pkg;

  localparam int CoefBits = 18;
  localparam int NumCoefs = 103;
  localparam int OutBits = 21;
  localparam int ThreshBits = 20;
  localparam int OutFrac = 8;
  localparam logic [ThreshBits-1:0] ThreshReset = 20'd95325;

  typedef logic signed [CoefBits-1:0] coef_t;
  typedef logic signed [OutBits-1:0] out_t;

  // Band-pass coefficients, signed Q1.17, symmetric around the center tap.
  localparam coef_t Coefs [NumCoefs] = '{
    -18'sd73, 18'sd794, -18'sd1656, 18'sd1489, -18'sd104, -18'sd827, 18'sd199, 18'sd631,
    -18'sd161, -18'sd590, 18'sd116, 18'sd603, -18'sd67, -18'sd646, 18'sd14, 18'sd703,
    18'sd48, -18'sd770, -18'sd123, 18'sd846, 18'sd212, -18'sd928, -18'sd318, 18'sd1013,
    18'sd446, -18'sd1099, -18'sd599, 18'sd1186, 18'sd784, -18'sd1273, -18'sd1006,
    18'sd1359, 18'sd1273, -18'sd1441, -18'sd1599, 18'sd1519, 18'sd2003, -18'sd1591,
    -18'sd2516, 18'sd1657, 18'sd3192, -18'sd1714, -18'sd4134, 18'sd1763, 18'sd5563,
    -18'sd1801, -18'sd8057, 18'sd1829, 18'sd13734, -18'sd1846, -18'sd41663, 18'sd67387,
    -18'sd41663, -18'sd1846, 18'sd13734, 18'sd1829, -18'sd8057, -18'sd1801, 18'sd5563,
    18'sd1763, -18'sd4134, -18'sd1714, 18'sd3192, 18'sd1657, -18'sd2516, -18'sd1591,
    18'sd2003, 18'sd1519, -18'sd1599, -18'sd1441, 18'sd1273, 18'sd1359, -18'sd1006,
    -18'sd1273, 18'sd784, 18'sd1186, -18'sd599, -18'sd1099, 18'sd446, 18'sd1013,
    -18'sd318, -18'sd928, 18'sd212, 18'sd846, -18'sd123, -18'sd770, 18'sd48, 18'sd703,
    18'sd14, -18'sd646, -18'sd67, 18'sd603, 18'sd116, -18'sd590, -18'sd161, 18'sd631,
    18'sd199, -18'sd827, -18'sd104, 18'sd1489, -18'sd1656, 18'sd794, -18'sd73
  };

endpackage

/* rtl/bfd_fir_cell.sv */
// One cell of the transposed FIR chain: multiply the broadcast sample by the
// tap coefficient, add the partial sum from the previous cell, register it.
module bfd_fir_cell #(
  parameter int SampleBits = 10,
  parameter int AccBits = 40
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [SampleBits-1:0]     sample_i,
  input  bfd_pkg::coef_t            coef_i,
  input  logic signed [AccBits-1:0] sum_i,
  output logic signed [AccBits-1:0] sum_o
);

  logic signed [SampleBits+bfd_pkg::CoefBits:0] prod;
  logic signed [AccBits-1:0] sum_d, sum_q;

  // Sample is unsigned, so a zero bit is prepended before the signed multiply.
  assign prod = $signed({1'b0, sample_i}) * coef_i;
  assign sum_d = sum_i + AccBits'(prod);

  // Partial sums reset to zero, which matches a zero-filled delay line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

/* rtl/bandpass_fir_threshold_detector.sv */
// A result is registered and shown in the cycle after its sample is accepted.
// Throughput: one sample per cycle unless a result is stalled; a transposed
// FIR chain, a cell per tap but the newest, adds every product on arrival.
// The output register advances whenever it is empty or being drained.
// Reset clears the partial sums (zero history), the valid flag, and loads
// the threshold with its reset value.
module bandpass_fir_threshold_detector #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     sample_valid_i,
  output logic                     sample_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [19:0]              detect_threshold_i,
  output logic                     result_valid_o,
  input  logic                     result_ready_i,
  output logic signed [20:0]       filtered_o,
  output logic                     detect_o
);

  localparam int Taps = bfd_pkg::NumCoefs;
  localparam int AccBits = SAMPLE_BITS + bfd_pkg::CoefBits + 10;
  localparam int Shift = bfd_pkg::CoefBits - 1 - bfd_pkg::OutFrac;
  localparam int OutBits = bfd_pkg::OutBits;

  logic                        advance;
  logic signed [AccBits-1:0]   chain [1:Taps];
  logic signed [AccBits-1:0]   acc;
  logic signed [AccBits-1:0]   rounded;
  logic signed [AccBits-1:0]   shifted;
  bfd_pkg::out_t               filt_d;
  logic                        det_d;
  logic [bfd_pkg::ThreshBits-1:0] thresh_q;
  logic                        valid_q;
  bfd_pkg::out_t               filt_q;
  logic                        det_q;

  assign advance = sample_valid_i && sample_ready_o;
  assign sample_ready_o = !valid_q || result_ready_i;
  assign cfg_ready_o = 1'b1;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= bfd_pkg::ThreshReset;
    end else if (cfg_valid_i) begin
      thresh_q <= detect_threshold_i;
    end
  end

  // Transposed chain: the oldest coefficient sits at the far end.
  assign chain[Taps] = '0;
  for (genvar k = 0; k < Taps - 1; k++) begin : g_cell
    bfd_fir_cell #(.SampleBits(SAMPLE_BITS), .AccBits(AccBits)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .sample_i(sample_i),
      .coef_i  (bfd_pkg::Coefs[k+1]),
      .sum_i   (chain[k+2]),
      .sum_o   (chain[k+1])
    );
  end

  // Newest tap plus the stored partial sum gives the full sum.
  assign acc = chain[1] + AccBits'($signed({1'b0, sample_i}) * bfd_pkg::Coefs[0]);
  assign rounded = acc + AccBits'(1 << (Shift - 1));
  assign shifted = rounded >>> Shift;

  // Saturate to the output range, then compare against the threshold.
  always_comb begin
    if (shifted > AccBits'((1 << (OutBits - 1)) - 1)) begin
      filt_d = {1'b0, {(OutBits-1){1'b1}}};
    end else if (shifted < -AccBits'(1 << (OutBits - 1))) begin
      filt_d = {1'b1, {(OutBits-1){1'b0}}};
    end else begin
      filt_d = OutBits'(shifted);
    end
    det_d = filt_d > $signed({1'b0, thresh_q});
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sample_ready_o) begin
      valid_q <= sample_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      filt_q <= filt_d;
      det_q <= det_d;
    end
  end

  assign result_valid_o = valid_q;
  assign filtered_o = filt_q;
  assign detect_o = det_q;

endmodule

/* rtl/bfd_checker.sv */
module bfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        sample_valid_i,
  input logic        sample_ready_o,
  input logic        result_valid_o,
  input logic        result_ready_i,
  input logic signed [20:0] filtered_o,
  input logic        detect_o
);

  // A result holds while it is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o && $stable(filtered_o))
    else $error("stalled result changed");

  // An accepted request yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && sample_ready_o |=> result_valid_o)
    else $error("missing result");

  // Input is always taken when the output is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> sample_ready_o)
    else $error("stall without pending result");

  // No result appears without a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sample_valid_i && sample_ready_o) && (!result_valid_o || result_ready_i)
    |=> !result_valid_o)
    else $error("spurious result");

  // A negative level never raises detect.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && filtered_o[20] |-> !detect_o)
    else $error("detect on negative level");

endmodule

bind bandpass_fir_threshold_detector bfd_checker u_bfd_checker (.*);
